>>> rtl/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds request codes, sequencer states and reset constants; depends on nothing.
`default_nettype none

package rrqs_pkg;

	localparam int DefNumSlots = 4;

	localparam int ReqW     = 2;
	localparam int SlotW    = 2;
	localparam int BurstW   = 16;
	localparam int ClockW   = 24;
	localparam int QuantumW = 8;

	localparam logic [QuantumW-1:0] QuantumRst = 8'd2;
	localparam logic [ClockW-1:0]   ClockMax   = 24'hFF_FFFF;

	typedef enum logic [ReqW-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/rrqs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the per-slot burst and remaining-work entries; no dependencies.
`default_nettype none

module rrqs_ram #(
	parameter int Width = 32,
	parameter int Depth = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/round_robin_quantum_scheduler.sv
// Round-robin quantum scheduler top level: sequencer, slot RAM and result register.
// Depends on rrqs_pkg and rrqs_ram.
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, req_type, slot, burst  item in, stall out
//  output    out_valid, out_stall, completed .. all_done item out, stall in
//  config    cfg_valid, cfg_ready, cfg_data             quantum write, always ready
//
// A load, start or unknown item goes from IDLE to RESULT. A tick runs through
// IDLE, TICK, SCAN and RESULT: one RAM read for the running slot, one
// read-modify-write, then the circular search reads one slot per cycle from
// the single RAM read port. One item is in work at a time; in_stall is high
// while the sequencer is busy and while a result waits on a stalled output
// register. Reset clears all slots through per-entry valid bits, no sweep.
`default_nettype none

module round_robin_quantum_scheduler #(
	parameter int NUM_SLOTS = rrqs_pkg::DefNumSlots
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rrqs_pkg::QuantumW-1:0] cfg_data,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [rrqs_pkg::ReqW-1:0]     req_type,
	input  wire logic [rrqs_pkg::SlotW-1:0]    slot,
	input  wire logic [rrqs_pkg::BurstW-1:0]   burst,
	// result items
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               completed,
	output logic      [rrqs_pkg::SlotW-1:0]    completed_slot,
	output logic      [rrqs_pkg::ClockW-1:0]   turnaround,
	output logic      [rrqs_pkg::ClockW-1:0]   waiting,
	output logic                               run_valid,
	output logic      [rrqs_pkg::SlotW-1:0]    run_slot,
	output logic                               all_done
);

	import rrqs_pkg::*;

	localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CntW   = $clog2(NUM_SLOTS + 1);
	localparam int EntryW = 2 * BurstW;
	localparam logic [SW-1:0]   LastSlot = SW'(NUM_SLOTS - 1);
	localparam logic [CntW-1:0] DoneMax  = CntW'(NUM_SLOTS);

	state_t state_q, state_d;

	logic [QuantumW-1:0] quantum_q;
	logic [ClockW-1:0]   clock_q;
	logic [CntW-1:0]     done_cnt_q;
	logic [SW-1:0]       cur_q;
	logic                running_q;
	logic [NUM_SLOTS-1:0] ent_vld_q;

	logic [SW-1:0] scan_idx_q;
	logic [SW-1:0] scan_cnt_q;
	logic          rd_vld_s1;

	logic              fin_q;
	logic [SW-1:0]     fin_slot_q;
	logic [ClockW-1:0] turn_q;
	logic [ClockW-1:0] wait_q;

	logic                out_valid_q;
	logic                completed_q;
	logic [SlotW-1:0]    completed_slot_q;
	logic [ClockW-1:0]   turnaround_q;
	logic [ClockW-1:0]   waiting_q;
	logic                run_valid_q;
	logic [SlotW-1:0]    run_slot_q;
	logic                all_done_q;

	logic              in_acc;
	logic              load_ok;
	logic              ram_we, ram_re;
	logic [SW-1:0]     ram_waddr, ram_raddr;
	logic [EntryW-1:0] ram_wdata, ram_rdata;
	logic [BurstW-1:0] rd_burst, rd_rem, new_rem;
	logic              rem_done;
	logic [ClockW:0]   clock_sum;
	logic [ClockW-1:0] clock_next;
	logic              out_load;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] idx);
		next_slot = (idx == LastSlot) ? '0 : idx + SW'(1);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_ok   = ({{(32-SlotW){1'b0}}, slot} < NUM_SLOTS);

	// entries never written read as zero
	assign rd_burst = rd_vld_s1 ? ram_rdata[EntryW-1:BurstW] : '0;
	assign rd_rem   = rd_vld_s1 ? ram_rdata[BurstW-1:0] : '0;
	assign rem_done = (rd_rem <= {{(BurstW-QuantumW){1'b0}}, quantum_q});
	assign new_rem  = rem_done ? '0 : rd_rem - {{(BurstW-QuantumW){1'b0}}, quantum_q};

	assign clock_sum  = {1'b0, clock_q} + {{(ClockW+1-QuantumW){1'b0}}, quantum_q};
	assign clock_next = clock_sum[ClockW] ? ClockMax : clock_sum[ClockW-1:0];

	rrqs_ram #(
		.Width(EntryW),
		.Depth(NUM_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = SW'(slot);
		ram_wdata = {burst, burst};
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req_t'(req_type) == REQ_LOAD && load_ok) begin
						ram_we = 1'b1;
					end
					if (req_t'(req_type) == REQ_TICK) begin
						ram_re  = 1'b1;
						state_d = ST_TICK;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_TICK: begin
				// write back the running slot, then start the search after it
				ram_we    = running_q;
				ram_waddr = cur_q;
				ram_wdata = {rd_burst, new_rem};
				ram_re    = 1'b1;
				ram_raddr = next_slot(cur_q);
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (rd_rem != '0 || scan_cnt_q == LastSlot) begin
					state_d = ST_RESULT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = next_slot(scan_idx_q);
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= QuantumRst;
			clock_q    <= '0;
			done_cnt_q <= '0;
			cur_q      <= '0;
			running_q  <= 1'b0;
			ent_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			scan_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			if (ram_we) begin
				ent_vld_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_s1 <= ent_vld_q[ram_raddr];
			end
			if (state_q == ST_IDLE && in_acc) begin
				if (req_t'(req_type) == REQ_START) begin
					clock_q    <= '0;
					done_cnt_q <= '0;
					cur_q      <= '0;
					running_q  <= 1'b1;
				end else if (req_t'(req_type) == REQ_TICK) begin
					clock_q <= clock_next;
				end
			end
			if (state_q == ST_TICK) begin
				scan_cnt_q <= '0;
				if (running_q) begin
					running_q <= 1'b0;
					if (rem_done && done_cnt_q != DoneMax) begin
						done_cnt_q <= done_cnt_q + CntW'(1);
					end
				end
			end
			if (state_q == ST_SCAN) begin
				if (rd_rem != '0) begin
					cur_q     <= scan_idx_q;
					running_q <= 1'b1;
				end else begin
					scan_cnt_q <= scan_cnt_q + SW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (ram_re) begin
			scan_idx_q <= ram_raddr;
		end
		if (state_q == ST_IDLE && in_acc) begin
			fin_q      <= 1'b0;
			fin_slot_q <= '0;
			turn_q     <= '0;
			wait_q     <= '0;
		end
		if (state_q == ST_TICK && running_q && rem_done) begin
			fin_q      <= 1'b1;
			fin_slot_q <= cur_q;
			turn_q     <= clock_q;
			wait_q     <= (clock_q > {{(ClockW-BurstW){1'b0}}, rd_burst}) ?
				clock_q - {{(ClockW-BurstW){1'b0}}, rd_burst} : '0;
		end
		if (out_load) begin
			completed_q      <= fin_q;
			completed_slot_q <= SlotW'(fin_slot_q);
			turnaround_q     <= turn_q;
			waiting_q        <= wait_q;
			run_valid_q      <= running_q;
			run_slot_q       <= SlotW'(cur_q);
			all_done_q       <= (done_cnt_q == DoneMax);
		end
	end

	assign out_valid      = out_valid_q;
	assign completed      = completed_q;
	assign completed_slot = completed_slot_q;
	assign turnaround     = turnaround_q;
	assign waiting        = waiting_q;
	assign run_valid      = run_valid_q;
	assign run_slot       = run_slot_q;
	assign all_done       = all_done_q;

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> state_q == ST_IDLE)
		else $error("item accepted while sequencer busy");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !ram_we)
		else $error("slot RAM written during search");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_cnt_q <= DoneMax)
		else $error("done count beyond slot count");

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32-SW){1'b0}}, cur_q} < NUM_SLOTS)
		else $error("running slot out of range");

	a_wait_le_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && completed_q |-> waiting_q <= turnaround_q)
		else $error("waiting exceeds turnaround");

endmodule

`default_nettype wire
